@@ src/slm_pkg.sv @@
// Shared types, register indexes and helpers for the solarize tone-curve block.
package slm_pkg;

  localparam int LevelWidth = 8;
  localparam int SignedWidth = 10;     // holds any difference of two levels
  localparam int FactorWidth = 11;     // curve position before scaling
  localparam int QuotWidth = 18;       // magnitude of the scaled numerator
  localparam int IndexWidth = 3;

  typedef logic [LevelWidth-1:0] level_t;
  typedef logic signed [SignedWidth-1:0] sdiff_t;

  typedef enum logic [IndexWidth-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_START     = 3'd1,
    REG_END       = 3'd2,
    REG_LIMIT     = 3'd3,
    REG_FLOOR     = 3'd4,
    REG_CEILING   = 3'd5
  } reg_index_t;

  typedef struct packed {
    level_t threshold_level;
    level_t start_level;
    level_t end_level;
    logic   limit_enable;
    level_t floor_level;
    level_t ceiling_level;
  } cfg_t;

  // A zero length counts as one.
  function automatic sdiff_t nonzero(input sdiff_t v);
    sdiff_t r;
    r = (v == '0) ? sdiff_t'(1) : v;
    return r;
  endfunction

endpackage

@@ src/slm_div_cell.sv @@
// One restoring-division step: shifts a dividend bit into the remainder, quotient bit out.
module slm_div_cell #(
  parameter int NW = 18,
  parameter int DW = 8,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid_in,
  input  logic [NW-1:0] num_in,
  input  logic [DW-1:0] rem_in,
  input  logic [DW-1:0] div_in,
  input  logic [SW-1:0] side_in,
  output logic          valid,
  output logic [NW-1:0] num,
  output logic [DW-1:0] rem,
  output logic [DW-1:0] div,
  output logic [SW-1:0] side
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [NW-1:0] num_next;
  logic [DW-1:0] rem_next;

  always_comb begin
    trial    = {rem_in, num_in[NW-1]};
    diff     = trial - {1'b0, div_in};
    ge       = (trial >= {1'b0, div_in});
    rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
    num_next = {num_in[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num  <= num_next;
      rem  <= rem_next;
      div  <= div_in;
      side <= side_in;
    end
  end

endmodule

@@ src/slm_channel.sv @@
// Tone-curve pipeline for one color channel: modulo chain, scaling, division chain.
module slm_channel #(
  parameter int CHANNEL_LEVELS = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  slm_pkg::cfg_t  cfg,
  input  logic           in_valid,
  input  slm_pkg::level_t level,
  output logic           out_valid,
  output slm_pkg::level_t result
);

  localparam int AMW = $clog2(CHANNEL_LEVELS + 256);
  localparam int AW  = AMW + 1;
  localparam int LW  = slm_pkg::LevelWidth;
  localparam int QW  = slm_pkg::QuotWidth;
  localparam int FW  = slm_pkg::FactorWidth;
  localparam int SDW = slm_pkg::SignedWidth;
  localparam int PW  = FW + SDW;

  // Curve lengths, static while items flow
  slm_pkg::sdiff_t period, up_len, down_len, height;
  always_comb begin
    period   = slm_pkg::nonzero(SDW'(cfg.end_level) - SDW'(cfg.start_level));
    up_len   = slm_pkg::nonzero(SDW'(cfg.threshold_level) - SDW'(cfg.start_level));
    down_len = slm_pkg::nonzero(SDW'(cfg.end_level) - SDW'(cfg.threshold_level));
    height   = SDW'(cfg.ceiling_level) - SDW'(cfg.floor_level);
  end

  // Modulo chain input
  logic signed [AW-1:0] dividend;
  logic [AMW-1:0]       dividend_mag;
  slm_pkg::sdiff_t      period_abs;
  always_comb begin
    dividend     = AW'(level) + AW'(CHANNEL_LEVELS) - AW'(cfg.start_level);
    dividend_mag = dividend[AW-1] ? AMW'(-dividend) : dividend[AMW-1:0];
    period_abs   = period[SDW-1] ? -period : period;
  end

  logic          mv   [AMW+1];
  logic [AMW-1:0] mn  [AMW+1];
  logic [LW-1:0] mr   [AMW+1];
  logic [LW-1:0] md   [AMW+1];
  logic [LW:0]   ms   [AMW+1];

  assign mv[0] = in_valid;
  assign mn[0] = dividend_mag;
  assign mr[0] = '0;
  assign md[0] = period_abs[LW-1:0];
  assign ms[0] = {dividend[AW-1], level};

  for (genvar i = 0; i < AMW; i++) begin : g_mod
    slm_div_cell #(.NW(AMW), .DW(LW), .SW(LW + 1)) u_cell (
      .clk, .rst, .en,
      .valid_in(mv[i]), .num_in(mn[i]), .rem_in(mr[i]), .div_in(md[i]), .side_in(ms[i]),
      .valid(mv[i+1]), .num(mn[i+1]), .rem(mr[i+1]), .div(md[i+1]), .side(ms[i+1])
    );
  end

  // Phase and curve segment
  slm_pkg::sdiff_t wrap_phase, clamp_phase, phase;
  logic signed [FW-1:0] factor;
  slm_pkg::sdiff_t      den;
  always_comb begin
    wrap_phase  = ms[AMW][LW] ? -SDW'(mr[AMW]) : SDW'(mr[AMW]);
    clamp_phase = SDW'(ms[AMW][LW-1:0]) - SDW'(cfg.start_level);
    if (clamp_phase < 0) begin
      clamp_phase = '0;
    end else if (clamp_phase > period - 1) begin
      clamp_phase = period - 1;
    end
    phase = cfg.limit_enable ? clamp_phase : wrap_phase;
    if (phase < up_len) begin
      factor = FW'(phase);
      den    = up_len;
    end else begin
      factor = FW'(down_len) - (FW'(phase) - FW'(up_len));
      den    = down_len;
    end
  end

  logic                 p_valid;
  logic signed [FW-1:0] p_factor;
  slm_pkg::sdiff_t      p_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= mv[AMW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_factor <= factor;
      p_den    <= den;
    end
  end

  // Scaling multiply feeding the division chain
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_abs;
  slm_pkg::sdiff_t      den_abs;
  always_comb begin
    prod     = PW'(p_factor) * PW'(height);
    prod_abs = prod[PW-1] ? -prod : prod;
    den_abs  = p_den[SDW-1] ? -p_den : p_den;
  end

  logic          dv [QW+1];
  logic [QW-1:0] dn [QW+1];
  logic [LW-1:0] dr [QW+1];
  logic [LW-1:0] dd [QW+1];
  logic          ds [QW+1];

  assign dv[0] = p_valid;
  assign dn[0] = prod_abs[QW-1:0];
  assign dr[0] = '0;
  assign dd[0] = den_abs[LW-1:0];
  assign ds[0] = prod[PW-1] ^ p_den[SDW-1];

  for (genvar j = 0; j < QW; j++) begin : g_div
    slm_div_cell #(.NW(QW), .DW(LW), .SW(1)) u_cell (
      .clk, .rst, .en,
      .valid_in(dv[j]), .num_in(dn[j]), .rem_in(dr[j]), .div_in(dd[j]), .side_in(ds[j]),
      .valid(dv[j+1]), .num(dn[j+1]), .rem(dr[j+1]), .div(dd[j+1]), .side(ds[j+1])
    );
  end

  // Offset by floor and saturate
  logic signed [QW+2:0] val;
  slm_pkg::level_t      sat;
  always_comb begin
    val = ds[QW] ? -(QW+3)'(dn[QW]) : (QW+3)'(dn[QW]);
    val = val + (QW+3)'(cfg.floor_level);
    if (val < 0) begin
      sat = '0;
    end else if (val > 255) begin
      sat = '1;
    end else begin
      sat = val[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= sat;
    end
  end

endmodule

@@ src/solarize_triangle_channel_map.sv @@
// Top level: solarize triangle tone curve on each color of an RGB pixel stream.
//
// Each pixel's red, green and blue levels pass through one triangle-wave tone
// curve set by six registers (threshold, start, end, limit, floor, ceiling).
// Throughput is one pixel per clock while the master side accepts. A chain of
// restoring-division cells works out the phase modulo, one stage picks the rising
// or falling segment, a multiply feeds an 18-cell division chain for the scaling,
// and an output register holds the result. The whole pipeline advances whenever
// the output register is empty or its transaction completes, so a stall on the
// master side holds every stage. Configuration writes are taken whenever reset is
// low (cfg_ready is high outside reset) and must only occur while no pixel is in
// flight; writes to unknown indexes are dropped. No transaction is taken on either
// input side during reset.
module solarize_triangle_channel_map #(
  parameter int CHANNEL_LEVELS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  slm_pkg::cfg_t cfg;
  logic          en;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_level <= 8'd128;
      cfg.start_level     <= 8'd0;
      cfg.end_level       <= 8'd255;
      cfg.limit_enable    <= 1'b0;
      cfg.floor_level     <= 8'd0;
      cfg.ceiling_level   <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        slm_pkg::REG_THRESHOLD: cfg.threshold_level <= cfg_data;
        slm_pkg::REG_START:     cfg.start_level     <= cfg_data;
        slm_pkg::REG_END:       cfg.end_level       <= cfg_data;
        slm_pkg::REG_LIMIT:     cfg.limit_enable    <= cfg_data[0];
        slm_pkg::REG_FLOOR:     cfg.floor_level     <= cfg_data;
        slm_pkg::REG_CEILING:   cfg.ceiling_level   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline moves when the output slot is free or being taken
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !rst;

  slm_channel #(.CHANNEL_LEVELS(CHANNEL_LEVELS)) u_red (
    .clk, .rst, .en, .cfg,
    .in_valid(s_tvalid), .level(s_tdata[7:0]),
    .out_valid(m_tvalid), .result(m_tdata[7:0])
  );

  slm_channel #(.CHANNEL_LEVELS(CHANNEL_LEVELS)) u_green (
    .clk, .rst, .en, .cfg,
    .in_valid(s_tvalid), .level(s_tdata[15:8]),
    .out_valid(), .result(m_tdata[15:8])
  );

  slm_channel #(.CHANNEL_LEVELS(CHANNEL_LEVELS)) u_blue (
    .clk, .rst, .en, .cfg,
    .in_valid(s_tvalid), .level(s_tdata[23:16]),
    .out_valid(), .result(m_tdata[23:16])
  );

endmodule

@@ dv/solarize_triangle_channel_map_tb.sv @@
// Testbench for the solarize tone-curve block: random pixels and settings, scoreboard check.
`timescale 1ns / 1ps

module solarize_triangle_channel_map_tb;

  localparam int Levels = 256;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 40;   // settle time after the last expected pixel has left

  // Scoreboard: predicts mapped pixels and checks what leaves the block.
  class pixel_scoreboard;
    logic [23:0] pending[$];
    int errors;
    logic [7:0] thr, st, en, flo, ceil;
    logic lim;

    function new();
      errors = 0;
      thr = 8'd128; st = 8'd0; en = 8'd255; lim = 1'b0; flo = 8'd0; ceil = 8'd255;
    endfunction

    function void set_reg(slm_pkg::reg_index_t idx, logic [7:0] val);
      case (idx)
        slm_pkg::REG_THRESHOLD: thr = val;
        slm_pkg::REG_START:     st = val;
        slm_pkg::REG_END:       en = val;
        slm_pkg::REG_LIMIT:     lim = val[0];
        slm_pkg::REG_FLOOR:     flo = val;
        slm_pkg::REG_CEILING:   ceil = val;
        default: ;
      endcase
    endfunction

    function logic [7:0] tone_curve(logic [7:0] lvl);
      longint period, up, down, height, phase, v;
      period = longint'(en) - longint'(st);
      if (period == 0) period = 1;
      up = longint'(thr) - longint'(st);
      if (up == 0) up = 1;
      down = longint'(en) - longint'(thr);
      if (down == 0) down = 1;
      height = longint'(ceil) - longint'(flo);
      if (lim) begin
        phase = longint'(lvl) - longint'(st);
        if (phase < 0) phase = 0;
        else if (phase > period - 1) phase = period - 1;
      end else begin
        // SV % truncates toward zero like C
        phase = (longint'(lvl) + longint'(Levels) - longint'(st)) % period;
      end
      if (phase < up) v = (phase * height) / up + longint'(flo);
      else v = ((down - (phase - up)) * height) / down + longint'(flo);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
    endfunction

    function void note_input(logic [23:0] px);
      pending.push_back({tone_curve(px[23:16]), tone_curve(px[15:8]), tone_curve(px[7:0])});
    endfunction

    task check_output(logic [23:0] got);
      logic [23:0] want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected output", '0, got);
        return;
      end
      want = pending.pop_front();
      for (int c = 0; c < 3; c++)
        if (got[c*8 +: 8] !== want[c*8 +: 8])
          report_mismatch(c == 0 ? "red_out" : (c == 1 ? "green_out" : "blue_out"),
                          24'(want[c*8 +: 8]), 24'(got[c*8 +: 8]));
    endtask

    task report_mismatch(string what, logic [23:0] want, logic [23:0] got);
      $display("mismatch %s: want %h got %h at %0t", what, want, got, $time);
      errors++;
    endtask
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready, cfg_valid, cfg_ready;
  logic [23:0] s_tdata, m_tdata;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;
  pixel_scoreboard sb;
  int cycles;
  bit quiet;   // no idling on either side while set

  solarize_triangle_channel_map uut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL solarize_triangle_channel_map");
      $finish;
    end
  end

  // Master side: random backpressure, check each accepted transaction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_output(m_tdata);
    m_tready <= rst ? 1'b0 : (quiet || $urandom_range(99) >= 12);
  end

  task automatic write_reg(slm_pkg::reg_index_t idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(logic [23:0] px);
    while (!quiet && $urandom_range(99) < 12) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(px);
  endtask

  // Wait until every expected pixel has come out, then idle a little.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic load_settings(logic [7:0] t, logic [7:0] s, logic [7:0] e, logic l,
                               logic [7:0] f, logic [7:0] c);
    write_reg(slm_pkg::REG_THRESHOLD, t);
    write_reg(slm_pkg::REG_START, s);
    write_reg(slm_pkg::REG_END, e);
    write_reg(slm_pkg::REG_LIMIT, {7'd0, l});
    write_reg(slm_pkg::REG_FLOOR, f);
    write_reg(slm_pkg::REG_CEILING, c);
  endtask

  initial begin
    sb = new();
    quiet = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset curve with extreme and mid levels
    send_pixel(24'h000000); send_pixel(24'hFFFFFF); send_pixel(24'h80807F);
    send_pixel(24'h01FE81);
    drain();
    // Zero lengths (start == end == threshold), with limiting
    load_settings(8'd50, 8'd50, 8'd50, 1'b1, 8'd10, 8'd200);
    send_pixel(24'h003250); send_pixel(24'hFF3331);
    drain();
    // Negative period, threshold outside range, inverted levels, wrap mode
    load_settings(8'd250, 8'd200, 8'd20, 1'b0, 8'd255, 8'd0);
    send_pixel(24'h00C814); send_pixel(24'hFFFA7F); send_pixel(24'h1501C9);
    drain();
    // Negative period under clamping
    write_reg(slm_pkg::REG_LIMIT, 8'd1);
    send_pixel(24'h00C814); send_pixel(24'hFFC9C7);
    drain();
    // Unknown register index is ignored
    cfg_valid <= 1'b1; cfg_index <= 3'd7; cfg_data <= 8'hAA;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    send_pixel(24'h123456);
    drain();

    // Random phases, each with fresh settings; one phase has no idling
    for (int ph = 0; ph < 18; ph++) begin
      quiet = (ph == 9);
      if (ph % 6 == 0) load_settings(8'd128, 8'd0, 8'd255, ph[0], 8'd0, 8'd255);
      else load_settings(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom_range(1)),
                         8'($urandom), 8'($urandom));
      for (int i = 0; i < 50; i++) send_pixel(24'($urandom));
      drain();
    end
    quiet = 1'b0;

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS solarize_triangle_channel_map");
    end else begin
      $display("FAIL solarize_triangle_channel_map");
    end
    $finish;
  end

endmodule
